>>> sv/set_assoc_cache_lru_tags_defines.svh
// assertion macros for the cache tag store
`ifndef SET_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH
`define SET_ASSOC_CACHE_LRU_TAGS_DEFINES_SVH
// assert that a implies b on the same edge
`define SACLT_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error("lbl");
// assert that a implies b on the next edge
`define SACLT_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("lbl");
`endif

>>> sv/saclt_pkg.sv
// ----------------------------------------------------------------------------
// saclt_pkg
// types and constants shared by the cache tag store modules
// ----------------------------------------------------------------------------
package saclt_pkg;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned BS_W   = 17;
  localparam int unsigned SC_W   = 9;
  localparam int unsigned WC_W   = 3;
  localparam int unsigned IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
  localparam logic [IDX_W-1:0] REG_SET_COUNT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_WAY_COUNT  = 2'd2;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } div_ctl_t;
endpackage

>>> sv/saclt_ram.sv
// ----------------------------------------------------------------------------
// saclt_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module saclt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end
endmodule

>>> sv/saclt_div.sv
// ----------------------------------------------------------------------------
// saclt_div
// restoring divider, one quotient bit a cycle
// ----------------------------------------------------------------------------
module saclt_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [saclt_pkg::ADDR_W-1:0] dividend,
  input  logic [saclt_pkg::BS_W-1:0]   divisor,
  output saclt_pkg::div_ctl_t        ctl,
  output logic [saclt_pkg::ADDR_W-1:0] quotient,
  output logic [saclt_pkg::BS_W-1:0]   remainder
);
  localparam int unsigned W = saclt_pkg::ADDR_W;
  localparam int unsigned D = saclt_pkg::BS_W;

  logic [W-1:0]         q_r, q_nxt;
  logic [D:0]           rem_r, rem_nxt;
  logic [D-1:0]         dvs_r, dvs_nxt;
  logic [$clog2(W):0]   cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt, done_r, done_nxt;
  logic [D+1:0]         trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[W-1]} - {2'b00, dvs_r};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; dvs_nxt = divisor;
      cnt_nxt = ($clog2(W)+1)'(W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[D+1]) begin
        rem_nxt = trial[D:0];
        q_nxt   = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[D-1:0], q_r[W-1]};
        q_nxt   = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ($clog2(W)+1)'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt;
  end

  assign ctl.start  = start;
  assign ctl.busy   = busy_r;
  assign ctl.done   = done_r;
  assign quotient   = q_r;
  assign remainder  = rem_r[D-1:0];
endmodule

>>> sv/set_assoc_cache_lru_tags.sv
// an accepted transaction takes two passes of the shared divider, then a read
// and a check state per way searched (stopping at a hit), then a write state
// before out_valid rises; one transaction at a time, the next accepted only
// once out_valid has been taken with out_ready high and the state is idle
// reset: synchronous; access counter cleared, config registers to 16, 64 and 4,
// then a pass that clears every line (1024 by default) before in_ready
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_tags
// tag store of a set-associative cache with timestamp lru replacement
// ----------------------------------------------------------------------------
module set_assoc_cache_lru_tags #(
  parameter int unsigned MAX_WAYS    = 4,
  parameter int unsigned MAX_SETS    = 256,
  parameter int unsigned STAMP_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_was_hit,
  output logic [1:0]  out_way_used,
  output logic [7:0]  out_set_sel,
  output logic        out_evicted_valid,
  output logic [31:0] out_evicted_tag
);
  localparam int unsigned WB = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SB = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned LINES = MAX_WAYS * MAX_SETS;
  localparam int unsigned LB = $clog2(LINES) > 0 ? $clog2(LINES) : 1;
  localparam int unsigned CW = $clog2(MAX_WAYS + 1);

  typedef enum logic [7:0] {
    S_CLR   = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_DIV1  = 8'b00000100,
    S_DIV2  = 8'b00001000,
    S_RD    = 8'b00010000,
    S_CHK   = 8'b00100000,
    S_WR    = 8'b01000000,
    S_OUT   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  logic [16:0] bs_r;
  logic [8:0]  sc_r;
  logic [2:0]  wc_r;
  logic [STAMP_WIDTH-1:0] ctr_r, ctr_nxt;
  logic [LB-1:0] clr_r, clr_nxt;

  logic [31:0] tag_r, tag_nxt;
  logic [SB-1:0] set_r, set_nxt;
  logic [WB-1:0] way_r, way_nxt, vic_r, vic_nxt;
  logic hit_r, hit_nxt, inv_r, inv_nxt;
  logic [STAMP_WIDTH-1:0] best_r, best_nxt;
  logic [31:0] otag_r, otag_nxt;
  logic [CW-1:0] ways_eff;
  logic [8:0] sets_eff;

  logic div_start;
  logic [31:0] div_a;
  logic [16:0] div_b;
  saclt_pkg::div_ctl_t div_ctl;
  logic [31:0] div_q;
  logic [16:0] div_r;

  logic tag_we, stp_we;
  logic [LB-1:0] ram_addr;
  logic [32:0] tag_wd;
  logic [32:0] tag_rd;
  logic line_vld;
  logic [STAMP_WIDTH-1:0] stp_rd;
  logic [LB-1:0] pos;

  logic ov_r, ov_nxt;
  logic o_hit_r, o_ev_r;
  logic [1:0] o_way_r;
  logic [7:0] o_set_r;
  logic [31:0] o_tag_r;

  always_comb begin
    if (wc_r == 3'd0) ways_eff = CW'(1);
    else if (32'(wc_r) > MAX_WAYS) ways_eff = CW'(MAX_WAYS);
    else ways_eff = CW'(wc_r);
    if (sc_r == 9'd0) sets_eff = 9'd1;
    else if (32'(sc_r) > MAX_SETS) sets_eff = 9'(MAX_SETS);
    else sets_eff = sc_r;
  end

  assign pos = LB'(32'(way_r) * MAX_SETS + 32'(set_r));
  assign ram_addr = (state_r == S_CLR) ? clr_r : pos;
  assign tag_wd = (state_r == S_CLR) ? 33'd0 : {1'b1, tag_r};
  assign line_vld = tag_rd[32];

  saclt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a), .divisor(div_b),
    .ctl(div_ctl), .quotient(div_q), .remainder(div_r)
  );

  // valid bit kept beside the tag
  saclt_ram #(.WIDTH(33), .DEPTH(LINES)) u_tag (
    .clk(clk), .we(tag_we), .addr(ram_addr), .wdata(tag_wd), .rdata(tag_rd)
  );
  saclt_ram #(.WIDTH(STAMP_WIDTH), .DEPTH(LINES)) u_stp (
    .clk(clk), .we(stp_we), .addr(ram_addr), .wdata(ctr_r), .rdata(stp_rd)
  );

  assign in_ready = (state_r == S_IDLE) && !ov_r;

  always_comb begin
    state_nxt = state_r; tag_nxt = tag_r; set_nxt = set_r; way_nxt = way_r;
    vic_nxt = vic_r; hit_nxt = hit_r; inv_nxt = inv_r; best_nxt = best_r;
    otag_nxt = otag_r; ctr_nxt = ctr_r; ov_nxt = ov_r; clr_nxt = clr_r;
    div_start = 1'b0; div_a = in_address;
    div_b = (bs_r == 17'd0) ? 17'd1 : bs_r;
    tag_we = 1'b0; stp_we = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_CLR: begin
        tag_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LB'(LINES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          div_start = 1'b1;
          ctr_nxt = ctr_r + 1'b1;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_ctl.done) begin
          div_start = 1'b1; div_a = div_q; div_b = 17'(sets_eff);
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_ctl.done) begin
          tag_nxt = div_q; set_nxt = SB'(div_r);
          way_nxt = '0; hit_nxt = 1'b0; inv_nxt = 1'b0; vic_nxt = '0;
          otag_nxt = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        if (line_vld && tag_rd[31:0] == tag_r && !hit_nxt) begin
          hit_nxt = 1'b1; vic_nxt = way_r;
        end else if (!line_vld && !inv_r && !hit_r) begin
          inv_nxt = 1'b1; vic_nxt = way_r;
        end else if (!hit_r && !inv_r && line_vld) begin
          if (way_r == '0 || stp_rd < best_r) begin
            best_nxt = stp_rd; vic_nxt = way_r; otag_nxt = tag_rd[31:0];
          end
        end
        if (hit_nxt || 32'(way_r) + 1 >= 32'(ways_eff)) begin
          way_nxt = hit_nxt ? way_r : vic_nxt;
          state_nxt = S_WR;
        end else begin
          way_nxt = way_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_WR: begin
        tag_we = 1'b1; stp_we = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; ctr_r <= '0; clr_r <= '0; ov_r <= 1'b0;
      bs_r <= 17'd16; sc_r <= 9'd64; wc_r <= 3'd4;
    end else begin
      state_r <= state_nxt; ctr_r <= ctr_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          saclt_pkg::REG_BLOCK_SIZE: bs_r <= cfg_data;
          saclt_pkg::REG_SET_COUNT:  sc_r <= cfg_data[8:0];
          saclt_pkg::REG_WAY_COUNT:  wc_r <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
    tag_r <= tag_nxt; set_r <= set_nxt; way_r <= way_nxt; vic_r <= vic_nxt;
    hit_r <= hit_nxt; inv_r <= inv_nxt; best_r <= best_nxt; otag_r <= otag_nxt;
    if (state_r == S_WR) begin
      o_hit_r <= hit_r;
      o_way_r <= 2'(way_r);
      o_set_r <= 8'(set_r);
      o_ev_r  <= !hit_r && !inv_r;
      o_tag_r <= (!hit_r && !inv_r) ? otag_r : 32'd0;
    end
  end

  assign out_valid         = ov_r;
  assign out_was_hit       = o_hit_r;
  assign out_way_used      = o_way_r;
  assign out_set_sel       = o_set_r;
  assign out_evicted_valid = o_ev_r;
  assign out_evicted_tag   = o_tag_r;
endmodule

>>> sv/saclt_checker.sv
// ----------------------------------------------------------------------------
// saclt_checker
// port-level checks for the cache tag store
// ----------------------------------------------------------------------------
`include "set_assoc_cache_lru_tags_defines.svh"
module saclt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_was_hit,
  input logic        out_evicted_valid,
  input logic [31:0] out_evicted_tag
);
  `SACLT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `SACLT_ASSERT_IMP(a_no_accept_while_out, out_valid, !in_ready)
  `SACLT_ASSERT_IMP(a_hit_no_evict, out_valid && out_was_hit, !out_evicted_valid)
  `SACLT_ASSERT_IMP(a_tag_zero, out_valid && !out_evicted_valid, out_evicted_tag == 32'd0)
  `SACLT_ASSERT_NXT(a_out_holds, out_valid && !out_ready, out_valid)
endmodule

bind set_assoc_cache_lru_tags saclt_checker u_saclt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_was_hit(out_was_hit),
  .out_evicted_valid(out_evicted_valid), .out_evicted_tag(out_evicted_tag)
);
